// ===== rtl/core/bounded_deque_defines.svh =====
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// concurrent check, off while reset is low
`define BD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check that also holds while reset is low
`define BD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/bd_pkg.sv =====
package bd_pkg;

  // fixed field widths
  localparam int unsigned DataW    = 32;
  localparam int unsigned CapW     = 11;
  localparam int unsigned ActW     = 3;
  localparam int unsigned DefDepth = 1024;

  localparam logic [CapW-1:0] CapReset = CapW'(1024);

  // action codes, unused codes act as a query
  typedef enum logic [ActW-1:0] {
    ActPushFront = 3'd0,
    ActPushBack  = 3'd1,
    ActPopFront  = 3'd2,
    ActPopBack   = 3'd3,
    ActQuery     = 3'd4
  } action_e;

  // input item
  typedef struct packed {
    logic [ActW-1:0]         action;
    logic signed [DataW-1:0] value;
  } in_t;

  // result item
  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] front_value;
    logic signed [DataW-1:0] rear_value;
    logic                    is_empty;
    logic                    is_full;
  } out_t;

  // finished result handed to the output register
  typedef struct packed {
    logic valid;
    out_t item;
  } res_t;

endpackage

// ===== rtl/core/bd_ram.sv =====
module bd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bd_ctrl.sv =====
`include "bounded_deque_defines.svh"

module bd_ctrl #(
  parameter int unsigned DEPTH = bd_pkg::DefDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bd_pkg::in_t                  in_i,
  // capacity register
  input  logic                         cap_we_i,
  input  logic [bd_pkg::CapW-1:0]      cap_i,
  // memory port
  output logic                         mem_we_o,
  output logic [$clog2(DEPTH)-1:0]     mem_waddr_o,
  output logic [bd_pkg::DataW-1:0]     mem_wdata_o,
  output logic                         mem_re_o,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr_o,
  input  logic [bd_pkg::DataW-1:0]     mem_rdata_i,
  // finished result
  output bd_pkg::res_t                 res_o,
  input  logic                         res_take_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > bd_pkg::CapW) ? CntW : bd_pkg::CapW;
  localparam int unsigned DW   = bd_pkg::DataW;

  localparam logic [AW-1:0]   LastIdx = AW'(DEPTH - 1);
  localparam logic [CmpW-1:0] DepthC  = CmpW'(DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] DepthN  = CntW'(DEPTH);
  localparam logic [DW-1:0]   NoValue = '1;

  // sequencer codes
  localparam logic StIdle   = 1'b0;
  localparam logic StFinish = 1'b1;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? LastIdx : i - AW'(1);
  endfunction

  logic                state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [AW-1:0]       tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [bd_pkg::CapW-1:0] cap_q;
  logic [DW-1:0]       front_q, front_d;
  logic [DW-1:0]       rear_q, rear_d;
  logic                ok_q, ok_d;
  logic                rd_front_q, rd_front_d;
  logic                rd_rear_q, rd_rear_d;

  logic                accept;
  logic                empty_now;
  logic                full_now;
  logic [CmpW-1:0]     cap_ext;
  logic [CmpW-1:0]     eff_cap;
  logic [DW-1:0]       front_res;
  logic [DW-1:0]       rear_res;
  logic                finish;

  // handshake, one item at a time
  assign in_stall_o = (state_q == StFinish);
  assign accept     = in_valid_i && (state_q == StIdle);

  // effective capacity and flags before the action
  assign cap_ext   = CmpW'(cap_q);
  assign eff_cap   = (cap_ext > DepthC) ? DepthC : cap_ext;
  assign empty_now = (count_q == '0);
  assign full_now  = (CmpW'(count_q) >= eff_cap);

  // action decode, pointer update and memory access
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    front_d     = front_q;
    rear_d      = rear_q;
    ok_d        = ok_q;
    rd_front_d  = rd_front_q;
    rd_rear_d   = rd_rear_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = in_i.value;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    if (accept) begin
      ok_d       = 1'b1;
      rd_front_d = 1'b0;
      rd_rear_d  = 1'b0;
      case (in_i.action)
        bd_pkg::ActPushFront: begin
          if (full_now) begin
            ok_d = 1'b0;
          end else begin
            head_d      = idx_dec(head_q);
            mem_we_o    = 1'b1;
            mem_waddr_o = idx_dec(head_q);
            count_d     = count_q + CntOne;
            front_d     = in_i.value;
            if (empty_now) begin
              rear_d = in_i.value;
            end
          end
        end
        bd_pkg::ActPushBack: begin
          if (full_now) begin
            ok_d = 1'b0;
          end else begin
            tail_d      = idx_inc(tail_q);
            mem_we_o    = 1'b1;
            mem_waddr_o = tail_q;
            count_d     = count_q + CntOne;
            rear_d      = in_i.value;
            if (empty_now) begin
              front_d = in_i.value;
            end
          end
        end
        bd_pkg::ActPopFront: begin
          if (empty_now) begin
            ok_d = 1'b0;
          end else begin
            head_d  = idx_inc(head_q);
            count_d = count_q - CntOne;
            // fetch the new front if anything remains
            if (count_q != CntOne) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = idx_inc(head_q);
              rd_front_d  = 1'b1;
            end
          end
        end
        bd_pkg::ActPopBack: begin
          if (empty_now) begin
            ok_d = 1'b0;
          end else begin
            tail_d  = idx_dec(tail_q);
            count_d = count_q - CntOne;
            // fetch the new rear if anything remains
            if (count_q != CntOne) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = idx_dec(idx_dec(tail_q));
              rd_rear_d   = 1'b1;
            end
          end
        end
        default: begin
          ok_d = 1'b1;
        end
      endcase
    end
  end

  // result assembly in the finish cycle
  assign front_res = rd_front_q ? mem_rdata_i : front_q;
  assign rear_res  = rd_rear_q ? mem_rdata_i : rear_q;
  assign finish    = (state_q == StFinish) && res_take_i;

  always_comb begin
    res_o.valid            = (state_q == StFinish);
    res_o.item.ok          = ok_q;
    res_o.item.front_value = (count_q == '0) ? NoValue : front_res;
    res_o.item.rear_value  = (count_q == '0) ? NoValue : rear_res;
    res_o.item.is_empty    = (count_q == '0);
    res_o.item.is_full     = (CmpW'(count_q) >= eff_cap);
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (res_take_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      cap_q      <= bd_pkg::CapReset;
      rd_front_q <= 1'b0;
      rd_rear_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (cap_we_i) begin
        cap_q <= cap_i;
      end
      if (finish) begin
        rd_front_q <= 1'b0;
        rd_rear_q  <= 1'b0;
      end else begin
        rd_front_q <= rd_front_d;
        rd_rear_q  <= rd_rear_d;
      end
    end
  end

  // cached end values, refreshed from the read data on finish
  always_ff @(posedge clk_i) begin
    ok_q <= ok_d;
    if (finish) begin
      front_q <= front_res;
      rear_q  <= rear_res;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
    end
  end

  // checks
  `BD_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> (state_q == StIdle && count_q == '0),
                    "reset did not clear sequencer and count")
  `BD_ASSERT(a_count_bound, count_q <= DepthN, "entry count above depth")
  `BD_ASSERT(a_empty_ptrs, (count_q == '0) |-> (head_q == tail_q),
             "empty deque with head and tail apart")
  `BD_ASSERT(a_accept_finish, accept |=> (state_q == StFinish),
             "accepted item did not reach finish")
  `BD_ASSERT(a_take_idle, (res_o.valid && res_take_i) |=> (state_q == StIdle && !rd_front_q),
             "result taken but sequencer not idle")

endmodule

// ===== rtl/core/bd_oreg.sv =====
module bd_oreg (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bd_pkg::res_t res_i,
  output logic         res_take_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output bd_pkg::out_t out_o
);

  logic         out_valid_q;
  bd_pkg::out_t out_q;

  // register can load when empty or being drained
  assign res_take_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take_o) begin
      out_valid_q <= res_i.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_take_o && res_i.valid) begin
      out_q <= res_i.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/core/bounded_deque.sv =====
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+------------------------
// in        | input     | in_valid_i / in_stall_o  | in_i (action, value)
// out       | output    | out_valid_o / out_stall_i| out_o (ok, front, rear, flags)
// cfg       | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (capacity)
//
// per item, the idle state updates head, tail and count and issues the
//   memory access; finish takes the registered data of the single read port
// the finished result sits in an output register, so a new item is taken
//   while the previous result still waits on out_stall_i
// a stalled output holds the controller in its finish cycle
// reset clears pointers and count and sets capacity to 1024; no clearing pass
module bounded_deque #(
  parameter int unsigned DEPTH = bd_pkg::DefDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  bd_pkg::in_t             in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output bd_pkg::out_t            out_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [bd_pkg::CapW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [bd_pkg::DataW-1:0]   mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [bd_pkg::DataW-1:0]   mem_rdata;
  bd_pkg::res_t               res;
  logic                       res_take;

  // capacity writes always taken
  assign cfg_ready_o = 1'b1;

  // ring storage
  bd_ram #(
    .Width (bd_pkg::DataW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // pointers, count and sequencing
  bd_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .cap_we_i    (cfg_valid_i && cfg_ready_o),
    .cap_i       (cfg_data_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // output register
  bd_oreg u_oreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_take_o  (res_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
